// ----- rtl/ole_pkg.sv -----
package ole_pkg;

  // defaults for the top level parameters
  localparam int DepthDef     = 64;
  localparam int ValueBitsDef = 32;

  // fixed field widths of the stream payload
  localparam int OpW    = 3;
  localparam int ItemW  = 32;
  localparam int PosW   = 7;
  localparam int StatW  = 2;
  localparam int CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_INS_AFTER  = 3'd2,
    OP_INS_BEFORE = 3'd3,
    OP_REM_FIRST  = 3'd4,
    OP_REM_LAST   = 3'd5,
    OP_FIND       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_NBR,
    ST_SRCH,
    ST_ALLOC,
    ST_ALLOC_W,
    ST_PLACE_NODE,
    ST_PLACE_LINK,
    ST_UNLINK_A,
    ST_UNLINK_B,
    ST_RESP
  } state_t;

  // write enables of the three node memories
  typedef struct packed {
    logic val;
    logic fwd;
    logic bwd;
  } mem_we_t;

  // finished result handed to the output stage
  typedef struct packed {
    logic         load;
    status_t      status;
    logic         found;
    logic [CountW-1:0] count;
  } result_t;

endpackage

// ----- rtl/ole_ram.sv -----
module ole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ole_seq.sv -----
module ole_seq #(
  parameter int DEPTH      = ole_pkg::DepthDef,
  parameter int VALUE_BITS = ole_pkg::ValueBitsDef,
  localparam int AW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ole_pkg::op_t                req_op,
  input  logic [VALUE_BITS-1:0]       req_value,
  input  logic [ole_pkg::PosW-1:0]    req_pos,
  input  logic                        res_ready,
  output ole_pkg::result_t            res,
  output ole_pkg::mem_we_t            we,
  output logic [AW-1:0]               raddr,
  output logic [AW-1:0]               val_waddr,
  output logic [VALUE_BITS-1:0]       val_wdata,
  output logic [AW-1:0]               fwd_waddr,
  output logic [LW-1:0]               fwd_wdata,
  output logic [AW-1:0]               bwd_waddr,
  output logic [LW-1:0]               bwd_wdata,
  input  logic [VALUE_BITS-1:0]       val_rdata,
  input  logic [LW-1:0]               fwd_rdata,
  input  logic [LW-1:0]               bwd_rdata
);

  localparam logic [LW-1:0] NIL  = LW'(DEPTH);
  localparam logic [LW-1:0] FULL = LW'(DEPTH);

  ole_pkg::state_t  state, state_next;
  ole_pkg::op_t     op;
  logic [VALUE_BITS-1:0] value;
  logic [ole_pkg::PosW-1:0] pos;
  logic [LW-1:0] cur, pred, succ, nnode, idx;
  logic [LW-1:0] head, tail, free_head, fresh, count;
  ole_pkg::status_t status;
  logic found;

  logic [LW-1:0] start;
  logic          pos_bad;
  logic          last_step;
  logic          at_end;
  logic [LW-1:0] step_next;

  assign start     = (req_op == ole_pkg::OP_REM_LAST) ? tail : head;
  assign pos_bad   = (req_pos == '0) || (32'(req_pos) > 32'(count));
  assign last_step = (32'(idx) + 32'd1) == 32'(pos);
  assign at_end    = (op == ole_pkg::OP_REM_LAST) ? (cur == head) : (cur == tail);
  assign step_next = (op == ole_pkg::OP_REM_LAST) ? bwd_rdata : fwd_rdata;

  assign req_ready = (state == ole_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ole_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req_op)
            ole_pkg::OP_APPEND, ole_pkg::OP_PREPEND: state_next = ole_pkg::ST_ALLOC;
            ole_pkg::OP_INS_AFTER, ole_pkg::OP_INS_BEFORE: begin
              if (pos_bad)           state_next = ole_pkg::ST_RESP;
              else if (req_pos == 1) state_next = ole_pkg::ST_NBR;
              else                   state_next = ole_pkg::ST_WALK;
            end
            ole_pkg::OP_REM_FIRST, ole_pkg::OP_REM_LAST, ole_pkg::OP_FIND: begin
              state_next = (start == NIL) ? ole_pkg::ST_RESP : ole_pkg::ST_SRCH;
            end
            default: state_next = ole_pkg::ST_RESP;
          endcase
        end
      end
      ole_pkg::ST_WALK: if (last_step) state_next = ole_pkg::ST_NBR;
      ole_pkg::ST_NBR:  state_next = ole_pkg::ST_ALLOC;
      ole_pkg::ST_SRCH: begin
        if (val_rdata == value) begin
          state_next = (op == ole_pkg::OP_FIND) ? ole_pkg::ST_RESP : ole_pkg::ST_UNLINK_A;
        end else if (at_end) begin
          state_next = ole_pkg::ST_RESP;
        end
      end
      ole_pkg::ST_ALLOC: begin
        if (count == FULL)        state_next = ole_pkg::ST_RESP;
        else if (free_head != NIL) state_next = ole_pkg::ST_ALLOC_W;
        else                       state_next = ole_pkg::ST_PLACE_NODE;
      end
      ole_pkg::ST_ALLOC_W:    state_next = ole_pkg::ST_PLACE_NODE;
      ole_pkg::ST_PLACE_NODE: state_next = ole_pkg::ST_PLACE_LINK;
      ole_pkg::ST_PLACE_LINK: state_next = ole_pkg::ST_RESP;
      ole_pkg::ST_UNLINK_A:   state_next = ole_pkg::ST_UNLINK_B;
      ole_pkg::ST_UNLINK_B:   state_next = ole_pkg::ST_RESP;
      ole_pkg::ST_RESP:       if (res_ready) state_next = ole_pkg::ST_IDLE;
      default:                state_next = ole_pkg::ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    we        = '0;
    raddr     = cur[AW-1:0];
    val_waddr = nnode[AW-1:0];
    val_wdata = value;
    fwd_waddr = nnode[AW-1:0];
    fwd_wdata = succ;
    bwd_waddr = nnode[AW-1:0];
    bwd_wdata = pred;
    case (state)
      ole_pkg::ST_IDLE: begin
        if (req_op == ole_pkg::OP_INS_AFTER || req_op == ole_pkg::OP_INS_BEFORE) begin
          raddr = head[AW-1:0];
        end else begin
          raddr = start[AW-1:0];
        end
      end
      ole_pkg::ST_WALK:  raddr = fwd_rdata[AW-1:0];
      ole_pkg::ST_SRCH:  raddr = step_next[AW-1:0];
      ole_pkg::ST_ALLOC: raddr = free_head[AW-1:0];
      ole_pkg::ST_PLACE_NODE: we = '{val: 1'b1, fwd: 1'b1, bwd: 1'b1};
      ole_pkg::ST_PLACE_LINK: begin
        we.fwd    = (pred != NIL);
        fwd_waddr = pred[AW-1:0];
        fwd_wdata = nnode;
        we.bwd    = (succ != NIL);
        bwd_waddr = succ[AW-1:0];
        bwd_wdata = nnode;
      end
      ole_pkg::ST_UNLINK_A: begin
        we.fwd    = (pred != NIL);
        fwd_waddr = pred[AW-1:0];
        fwd_wdata = succ;
        we.bwd    = (succ != NIL);
        bwd_waddr = succ[AW-1:0];
        bwd_wdata = pred;
      end
      ole_pkg::ST_UNLINK_B: begin
        we.fwd    = 1'b1;
        fwd_waddr = cur[AW-1:0];
        fwd_wdata = free_head;
      end
      default: ;
    endcase
  end

  // result toward the output stage
  always_comb begin
    res.load   = (state == ole_pkg::ST_RESP) && res_ready;
    res.status = status;
    res.found  = found;
    res.count  = ole_pkg::CountW'(count);
  end

  // list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ole_pkg::ST_IDLE;
      head      <= NIL;
      tail      <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      case (state)
        ole_pkg::ST_IDLE: begin
          if (req_valid && req_op == ole_pkg::OP_CLEAR) begin
            head      <= NIL;
            tail      <= NIL;
            free_head <= NIL;
            fresh     <= '0;
            count     <= '0;
          end
        end
        ole_pkg::ST_ALLOC: begin
          if (count != FULL && free_head == NIL) begin
            fresh <= fresh + 1'b1;
          end
        end
        ole_pkg::ST_ALLOC_W: free_head <= fwd_rdata;
        ole_pkg::ST_PLACE_LINK: begin
          if (pred == NIL) head <= nnode;
          if (succ == NIL) tail <= nnode;
          count <= count + 1'b1;
        end
        ole_pkg::ST_UNLINK_A: begin
          if (pred == NIL) head <= succ;
          if (succ == NIL) tail <= pred;
        end
        ole_pkg::ST_UNLINK_B: begin
          free_head <= cur;
          count     <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // per request working registers
  always_ff @(posedge clk) begin
    case (state)
      ole_pkg::ST_IDLE: begin
        op     <= req_op;
        value  <= req_value;
        pos    <= req_pos;
        idx    <= LW'(1);
        status <= ole_pkg::STAT_OK;
        found  <= 1'b0;
        pred   <= tail;
        succ   <= NIL;
        cur    <= start;
        case (req_op)
          ole_pkg::OP_PREPEND: begin
            pred <= NIL;
            succ <= head;
          end
          ole_pkg::OP_INS_AFTER, ole_pkg::OP_INS_BEFORE: begin
            cur <= head;
            if (pos_bad) status <= ole_pkg::STAT_MISSING;
          end
          ole_pkg::OP_REM_FIRST, ole_pkg::OP_REM_LAST, ole_pkg::OP_FIND: begin
            if (start == NIL) status <= ole_pkg::STAT_MISSING;
          end
          default: ;
        endcase
      end
      ole_pkg::ST_WALK: begin
        cur <= fwd_rdata;
        idx <= idx + 1'b1;
      end
      ole_pkg::ST_NBR: begin
        if (op == ole_pkg::OP_INS_AFTER) begin
          pred <= cur;
          succ <= (cur == tail) ? NIL : fwd_rdata;
        end else begin
          succ <= cur;
          pred <= (cur == head) ? NIL : bwd_rdata;
        end
      end
      ole_pkg::ST_SRCH: begin
        if (val_rdata == value) begin
          found <= 1'b1;
          pred  <= (cur == head) ? NIL : bwd_rdata;
          succ  <= (cur == tail) ? NIL : fwd_rdata;
        end else if (at_end) begin
          status <= ole_pkg::STAT_MISSING;
        end else begin
          cur <= step_next;
        end
      end
      ole_pkg::ST_ALLOC: begin
        if (count == FULL)         status <= ole_pkg::STAT_FULL;
        else if (free_head != NIL) nnode  <= free_head;
        else                       nnode  <= fresh;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ole_out.sv -----
module ole_out (
  input  logic                              clk,
  input  logic                              rst,
  input  ole_pkg::result_t                  res,
  output logic                              res_ready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata
);

  logic [ole_pkg::StatW-1:0]  status;
  logic                       found;
  logic [ole_pkg::CountW-1:0] count;

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {6'd0, count, found, status};

  // output register, reloaded as soon as the held response leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      status <= res.status;
      found  <= res.found;
      count  <= res.count;
    end
  end

endmodule

// ----- rtl/ordered_list_engine.sv -----
// Ordered list of signed values held in a pool of DEPTH linked nodes.
// Input stream s_*: one request per operation (append, prepend, insert
// after or before a 1-based position, remove first or last occurrence,
// find, clear). Output stream m_*: exactly one response per request with
// status, found flag and the element count after the operation.
// Requests are handled one at a time; s_tready is high while the engine
// is idle. Paths from acceptance to the response being loaded:
//   append / prepend        allocate, write and link a node, or stop at a full pool
//   insert at position p    walk to node p (one forward link read per step),
//                           then as append; a bad position skips to the response
//   remove / find           walk up to n elements (one node read a
//                           step through the value and link memories),
//                           a removal then unlinks the node and frees it
//   clear                   resets head, tail, free list and count
// The node values and both link memories share one read address and
// return registered data the cycle after, which sets the walk rate of one node a cycle.
// Reset empties the list at once; no memory sweep is needed since unused
// nodes are handed out from a fill counter. A stalled m_tready holds the
// response in the output register and the next request waits for it.
module ordered_list_engine #(
  parameter int DEPTH      = ole_pkg::DepthDef,
  parameter int VALUE_BITS = ole_pkg::ValueBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // op[2:0], item_value[34:3], position[41:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], found[2], element_count[9:3]
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  logic signed [ole_pkg::ItemW-1:0] item;
  logic signed [63:0]               item_ext;
  logic [VALUE_BITS-1:0]            req_value;
  ole_pkg::op_t                     req_op;
  logic [ole_pkg::PosW-1:0]         req_pos;

  ole_pkg::result_t  res;
  ole_pkg::mem_we_t  we;
  logic              res_ready;
  logic [AW-1:0]     raddr, val_waddr, fwd_waddr, bwd_waddr;
  logic [VALUE_BITS-1:0] val_wdata, val_rdata;
  logic [LW-1:0]     fwd_wdata, bwd_wdata, fwd_rdata, bwd_rdata;

  // unpack the request and size the value
  assign req_op    = ole_pkg::op_t'(s_tdata[2:0]);
  assign item      = s_tdata[34:3];
  assign req_pos   = s_tdata[41:35];
  assign item_ext  = 64'(item);
  assign req_value = item_ext[VALUE_BITS-1:0];

  ole_seq #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_op    (req_op),
    .req_value (req_value),
    .req_pos   (req_pos),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .raddr     (raddr),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .fwd_waddr (fwd_waddr),
    .fwd_wdata (fwd_wdata),
    .bwd_waddr (bwd_waddr),
    .bwd_wdata (bwd_wdata),
    .val_rdata (val_rdata),
    .fwd_rdata (fwd_rdata),
    .bwd_rdata (bwd_rdata)
  );

  ole_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (we.val),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  ole_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_fwd_ram (
    .clk   (clk),
    .we    (we.fwd),
    .waddr (fwd_waddr),
    .wdata (fwd_wdata),
    .raddr (raddr),
    .rdata (fwd_rdata)
  );

  ole_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_bwd_ram (
    .clk   (clk),
    .we    (we.bwd),
    .waddr (bwd_waddr),
    .wdata (bwd_wdata),
    .raddr (raddr),
    .rdata (bwd_rdata)
  );

  ole_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .res_ready (res_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
